>>> rtl/nsrp_pkg.sv
// ---------------------------------------------------------------------------
// Netstring request parser package
// Shared phase type, result kinds, character codes and the result struct.
// ---------------------------------------------------------------------------
`default_nettype none

package nsrp_pkg;

    typedef enum logic [3:0] {
        PH_UID_LEN,
        PH_UID_VAL,
        PH_UID_COMMA,
        PH_CNT_LEN,
        PH_CNT_VAL,
        PH_CNT_COMMA,
        PH_BLK_LEN,
        PH_BLK_DATA,
        PH_BLK_COMMA,
        PH_DONE
    } phase_t;

    localparam logic [2:0] KIND_UID    = 3'd0;
    localparam logic [2:0] KIND_COUNT  = 3'd1;
    localparam logic [2:0] KIND_ARG    = 3'd2;
    localparam logic [2:0] KIND_ACCEPT = 3'd3;
    localparam logic [2:0] KIND_ERROR  = 3'd4;

    localparam logic [33:0] LEN_LIMIT  = 34'd999999999;
    localparam logic [7:0]  CHAR_COLON = 8'h3A;
    localparam logic [7:0]  CHAR_COMMA = 8'h2C;
    localparam logic [7:0]  CHAR_ZERO  = 8'h30;

    typedef struct packed {
        logic        valid;
        logic [2:0]  kind;
        logic [31:0] value;
        logic        arg_end;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/nsrp_engine.sv
// ---------------------------------------------------------------------------
// Netstring request parser engine
// Holds the parse state and works out one byte's result per cycle if stepped.
// ---------------------------------------------------------------------------
`default_nettype none

module nsrp_engine
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [7:0]       in_byte,
    input  wire logic             stream_end,
    output nsrp_pkg::result_t     res
);

    nsrp_pkg::phase_t phase_reg;
    nsrp_pkg::phase_t phase_next;
    logic [33:0]      len_reg;
    logic [33:0]      len_next;
    logic [31:0]      acc_reg;
    logic [31:0]      acc_next;
    logic [31:0]      count_reg;
    logic [31:0]      count_next;
    logic [33:0]      nul_reg;
    logic [33:0]      nul_next;

    logic [7:0]  digit;
    logic        is_digit;
    logic        is_colon;
    logic        is_comma;
    logic        is_nul;
    logic        len_over;
    logic        len_zero;
    logic [33:0] len_mul;
    logic [33:0] len_dec;
    logic        last_byte;
    logic [31:0] acc_mul;
    logic [33:0] nul_inc;
    logic        count_ok;
    logic        active;

    assign digit     = in_byte - nsrp_pkg::CHAR_ZERO;
    assign is_digit  = digit < 8'd10;
    assign is_colon  = in_byte == nsrp_pkg::CHAR_COLON;
    assign is_comma  = in_byte == nsrp_pkg::CHAR_COMMA;
    assign is_nul    = in_byte == 8'd0;
    assign len_over  = len_reg > nsrp_pkg::LEN_LIMIT;
    assign len_zero  = len_reg == 34'd0;
    assign len_mul   = {len_reg[30:0], 3'b000} + {len_reg[32:0], 1'b0} + {26'd0, digit};
    assign len_dec   = len_reg - 34'd1;
    assign last_byte = len_dec == 34'd0;
    assign acc_mul   = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0} + {24'd0, digit};
    assign nul_inc   = nul_reg + {33'd0, is_nul};
    assign count_ok  = !count_reg[31] && (nul_inc == {2'b00, count_reg});
    assign active    = step && (phase_reg != nsrp_pkg::PH_DONE);

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        acc_next   = acc_reg;
        count_next = count_reg;
        nul_next   = nul_reg;
        if (active)
        begin
            if (stream_end)
            begin
                phase_next = nsrp_pkg::PH_DONE;
            end
            else
            begin
                unique case (phase_reg)
                    nsrp_pkg::PH_UID_LEN, nsrp_pkg::PH_CNT_LEN:
                    begin
                        if (is_colon)
                        begin
                            acc_next = 32'd0;
                            if (phase_reg == nsrp_pkg::PH_UID_LEN)
                                phase_next = len_zero ? nsrp_pkg::PH_UID_COMMA
                                                      : nsrp_pkg::PH_UID_VAL;
                            else
                                phase_next = len_zero ? nsrp_pkg::PH_CNT_COMMA
                                                      : nsrp_pkg::PH_CNT_VAL;
                        end
                        else if (!is_digit || len_over)
                            phase_next = nsrp_pkg::PH_DONE;
                        else
                            len_next = len_mul;
                    end
                    nsrp_pkg::PH_UID_VAL, nsrp_pkg::PH_CNT_VAL:
                    begin
                        if (!is_digit)
                            phase_next = nsrp_pkg::PH_DONE;
                        else
                        begin
                            acc_next = acc_mul;
                            len_next = len_dec;
                            if (last_byte)
                                phase_next = (phase_reg == nsrp_pkg::PH_UID_VAL)
                                             ? nsrp_pkg::PH_UID_COMMA
                                             : nsrp_pkg::PH_CNT_COMMA;
                        end
                    end
                    nsrp_pkg::PH_UID_COMMA:
                    begin
                        if (!is_comma)
                            phase_next = nsrp_pkg::PH_DONE;
                        else
                        begin
                            len_next   = 34'd0;
                            phase_next = nsrp_pkg::PH_CNT_LEN;
                        end
                    end
                    nsrp_pkg::PH_CNT_COMMA:
                    begin
                        if (!is_comma)
                            phase_next = nsrp_pkg::PH_DONE;
                        else
                        begin
                            count_next = acc_reg;
                            len_next   = 34'd0;
                            phase_next = nsrp_pkg::PH_BLK_LEN;
                        end
                    end
                    nsrp_pkg::PH_BLK_LEN:
                    begin
                        if (is_colon)
                        begin
                            if (len_zero)
                                phase_next = nsrp_pkg::PH_DONE;
                            else
                            begin
                                nul_next   = 34'd0;
                                phase_next = nsrp_pkg::PH_BLK_DATA;
                            end
                        end
                        else if (!is_digit || len_over)
                            phase_next = nsrp_pkg::PH_DONE;
                        else
                            len_next = len_mul;
                    end
                    nsrp_pkg::PH_BLK_DATA:
                    begin
                        nul_next = nul_inc;
                        len_next = len_dec;
                        if (last_byte)
                            phase_next = (!is_nul || !count_ok) ? nsrp_pkg::PH_DONE
                                                                : nsrp_pkg::PH_BLK_COMMA;
                    end
                    default:
                    begin
                        phase_next = nsrp_pkg::PH_DONE;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        res = '{valid: 1'b0, kind: nsrp_pkg::KIND_ERROR, value: 32'd0, arg_end: 1'b0};
        if (active)
        begin
            if (stream_end)
                res.valid = 1'b1;
            else
            begin
                unique case (phase_reg)
                    nsrp_pkg::PH_UID_LEN, nsrp_pkg::PH_CNT_LEN:
                        res.valid = !is_colon && (!is_digit || len_over);
                    nsrp_pkg::PH_BLK_LEN:
                        res.valid = is_colon ? len_zero : (!is_digit || len_over);
                    nsrp_pkg::PH_UID_VAL, nsrp_pkg::PH_CNT_VAL:
                        res.valid = !is_digit;
                    nsrp_pkg::PH_UID_COMMA:
                    begin
                        res.valid = 1'b1;
                        if (is_comma)
                        begin
                            res.kind  = nsrp_pkg::KIND_UID;
                            res.value = acc_reg;
                        end
                    end
                    nsrp_pkg::PH_CNT_COMMA:
                    begin
                        res.valid = 1'b1;
                        if (is_comma)
                        begin
                            res.kind  = nsrp_pkg::KIND_COUNT;
                            res.value = acc_reg;
                        end
                    end
                    nsrp_pkg::PH_BLK_DATA:
                    begin
                        res.valid = 1'b1;
                        if (!(last_byte && (!is_nul || !count_ok)))
                        begin
                            res.kind    = nsrp_pkg::KIND_ARG;
                            res.value   = {24'd0, in_byte};
                            res.arg_end = is_nul;
                        end
                    end
                    nsrp_pkg::PH_BLK_COMMA:
                    begin
                        res.valid = 1'b1;
                        if (is_comma)
                            res.kind = nsrp_pkg::KIND_ACCEPT;
                    end
                    default:
                    begin
                        res.valid = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= nsrp_pkg::PH_UID_LEN;
            len_reg   <= 34'd0;
            acc_reg   <= 32'd0;
            count_reg <= 32'd0;
            nul_reg   <= 34'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            acc_reg   <= acc_next;
            count_reg <= count_next;
            nul_reg   <= nul_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/netstring_request_parser.sv
// ---------------------------------------------------------------------------
// Netstring request parser
// Parses a uid, an argument count and an argument block from a byte stream.
// ---------------------------------------------------------------------------
// Pipeline: a beat is taken into the input register, and the engine's result
// for it is registered in the output register once the output side has room.
// Throughput: one input beat per cycle while the output side is ready.
// The engine's state update for each beat sets that figure.
// Reset clears the parse state and the valid flags of both pipeline registers.
`default_nettype none

module netstring_request_parser
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic        s_axis_tuser,   // [0] stream_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] value
    output logic [2:0]       m_axis_tuser,   // [2:0] kind
    output logic             m_axis_tlast    // arg_end
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_end_reg;
    logic              out_valid_reg;
    logic [31:0]       out_value_reg;
    logic [2:0]        out_kind_reg;
    logic              out_end_reg;
    logic              advance;
    logic              out_free;
    nsrp_pkg::result_t res;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || advance;

    nsrp_engine u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .in_byte    (in_byte_reg),
        .stream_end (in_end_reg),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (out_free)
                out_valid_reg <= advance && res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_end_reg  <= s_axis_tuser;
        end
        if (advance && res.valid)
        begin
            out_value_reg <= res.value;
            out_kind_reg  <= res.kind;
            out_end_reg   <= res.arg_end;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_end_reg;

    a_result_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> advance)
        else $error("Result produced without a beat in the input register.");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)
                                        && $stable(in_end_reg)))
        else $error("Stalled input beat was lost or changed.");

    a_end_only_on_arg: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.arg_end) |-> (res.kind == nsrp_pkg::KIND_ARG))
        else $error("Argument end mark on a non-argument result.");

    a_final_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && (res.kind == nsrp_pkg::KIND_ACCEPT
                       || res.kind == nsrp_pkg::KIND_ERROR)) |-> (res.value == 32'd0))
        else $error("Accept or error result carries a nonzero value.");

endmodule

`default_nettype wire
